/* design/tilt_average_and_screen_map_core_macros.svh */
// Assertion macros shared by the tilt averaging block.
// Every macro is sampled on clk and is switched off while rst_n is low.
`ifndef TILT_AVERAGE_AND_SCREEN_MAP_CORE_MACROS_SVH
`define TILT_AVERAGE_AND_SCREEN_MAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TASM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define TASM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TASM_ASSERT_NOW(label, ante, cons, msg)
`define TASM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/tasm_pkg.sv */
package tasm_pkg;

  // Widths of the averages and of the calibration registers.
  localparam int MEAN_W     = 10;
  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_X_RAW_LOW  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_X_RAW_HIGH = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_RAW_LOW  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_RAW_HIGH = CFG_ADDR_W'(3);

  // Calibration values after reset.
  localparam logic [CFG_W-1:0] RAW_LOW_RST  = CFG_W'(370);
  localparam logic [CFG_W-1:0] RAW_HIGH_RST = CFG_W'(590);

  // Signed difference of two averages, and the magnitude of span * difference.
  // The widest span is 98, so the product stays below 2**17.
  localparam int DIFF_W = MEAN_W + 1;
  localparam int Q_W    = 17;

  // Screen positions are at most 7 bits wide.
  localparam int POS_W = 7;

  // Four kinds of position, each mapped from the new and from the previous averages.
  localparam int NUM_KINDS  = 4;
  localparam int NUM_MAPS   = 2 * NUM_KINDS;
  localparam int KIND_BAR_X = 0;
  localparam int KIND_BAR_Y = 1;
  localparam int KIND_BUB_X = 2;
  localparam int KIND_BUB_Y = 3;

  // Pixel ranges, indexed by kind.
  localparam int PIX_LO [NUM_KINDS] = '{22, 6, 22, 21};
  localparam int PIX_HI [NUM_KINDS] = '{120, 57, 58, 57};

  // Result word: two averages and eight positions, padded to whole bytes.
  localparam int OUT_W = 72;

  // What a map lane hands to the merging stage.
  typedef struct packed {
    logic           force_lo;
    logic [Q_W-1:0] quo;
  } map_res_t;

  // Clamp a lane quotient into its pixel range.
  function automatic logic [POS_W-1:0] clamp_pos(input map_res_t r, input int plo,
                                                 input int phi);
    logic [Q_W-1:0]   span;
    logic [POS_W-1:0] lo_v;
    logic [POS_W-1:0] hi_v;
    span = Q_W'(phi - plo);
    lo_v = POS_W'(plo);
    hi_v = POS_W'(phi);
    if (r.force_lo) begin
      clamp_pos = lo_v;
    end else if (r.quo > span) begin
      clamp_pos = hi_v;
    end else begin
      clamp_pos = lo_v + r.quo[POS_W-1:0];
    end
  endfunction

endpackage

/* design/tasm_mean_lane.sv */
module tasm_mean_lane
  import tasm_pkg::*;
#(
  parameter int SAMPLE_BITS   = 10,
  parameter int BLOCK_SAMPLES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   last,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [MEAN_W-1:0]      mean,
  output logic                   done
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);
  localparam int REC_SH = SUM_W + $clog2(BLOCK_SAMPLES);
  localparam int REC_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + REC_W;

  // Reciprocal of the block length, rounded up; the quotient is exact for every
  // sum below 2**SUM_W.
  localparam logic [REC_W-1:0] REC_M =
    REC_W'(((64'd1 << REC_SH) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES));

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  work_r;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;
  logic [MEAN_W-1:0] mean_r;
  logic              busy_r;
  logic              done_r;

  // Running sum of the current block.
  assign sum_nxt = sum_r + SUM_W'(sample);

  // Divide by the block length as a multiply by its reciprocal.
  assign prod = PROD_W'(work_r) * PROD_W'(REC_M);
  assign quo  = prod >> REC_SH;

  // Sum and averaging control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (accept) begin
        sum_r <= last ? '0 : sum_nxt;
      end
      if (accept && last) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The finished sum is registered first, and in the next cycle its average is registered.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      work_r <= sum_nxt;
    end
    if (busy_r) begin
      mean_r <= MEAN_W'(quo);
    end
  end

  assign mean = mean_r;
  assign done = done_r;

endmodule

/* design/tasm_map_lane.sv */
module tasm_map_lane
  import tasm_pkg::*;
#(
  parameter int SPAN = 98
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MEAN_W-1:0] value,
  input  logic [CFG_W-1:0]  raw_lo,
  input  logic [CFG_W-1:0]  raw_hi,
  output map_res_t          res,
  output logic              done
);

  localparam int STEP_W = $clog2(Q_W);
  localparam logic [Q_W-1:0] SPAN_V = Q_W'(SPAN);

  logic [DIFF_W-1:0] den;
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] den_neg;
  logic [DIFF_W-1:0] diff_neg;
  logic [MEAN_W-1:0] den_mag;
  logic [MEAN_W-1:0] diff_mag;
  logic [Q_W-1:0]    num_mag;
  logic [Q_W-1:0]    work_r;
  logic [MEAN_W-1:0] dvs_r;
  logic [MEAN_W-1:0] rem_r;
  logic [MEAN_W:0]   rem_t;
  logic [MEAN_W:0]   rem_sub;
  logic              ge;
  logic              force_lo_r;
  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;

  // Signed slope terms, split into sign and magnitude.
  assign den      = {1'b0, raw_hi} - {1'b0, raw_lo};
  assign diff     = {1'b0, value} - {1'b0, raw_lo};
  assign den_neg  = DIFF_W'(0) - den;
  assign diff_neg = DIFF_W'(0) - diff;
  assign den_mag  = den[DIFF_W-1] ? den_neg[MEAN_W-1:0] : den[MEAN_W-1:0];
  assign diff_mag = diff[DIFF_W-1] ? diff_neg[MEAN_W-1:0] : diff[MEAN_W-1:0];
  assign num_mag  = SPAN_V * Q_W'(diff_mag);

  // One restoring step of the magnitude divide.
  assign rem_t   = {rem_r, work_r[Q_W-1]};
  assign ge      = rem_t >= {1'b0, dvs_r};
  assign rem_sub = rem_t - {1'b0, dvs_r};

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // A negative quotient, a zero quotient of opposite signs and equal raw bounds
  // all land on the low pixel bound, so only a positive quotient is divided out.
  always_ff @(posedge clk) begin
    if (start) begin
      work_r     <= num_mag;
      dvs_r      <= den_mag;
      rem_r      <= '0;
      force_lo_r <= (den == '0) || (den[DIFF_W-1] ^ diff[DIFF_W-1]);
    end else if (busy_r) begin
      work_r <= {work_r[Q_W-2:0], ge};
      rem_r  <= ge ? rem_sub[MEAN_W-1:0] : rem_t[MEAN_W-1:0];
    end
  end

  assign res  = '{force_lo: force_lo_r, quo: work_r};
  assign done = done_r;

endmodule

/* design/tasm_merge.sv */
module tasm_merge
  import tasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [MEAN_W-1:0] mean_x,
  input  logic [MEAN_W-1:0] mean_y,
  input  map_res_t          res [NUM_MAPS],
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              can_load
);

  logic [POS_W-1:0] pos [NUM_MAPS];
  logic [OUT_W-1:0] data_nxt;
  logic [OUT_W-1:0] data_r;
  logic             valid_r;

  // Clamp every lane into the pixel range of its kind.
  for (genvar g = 0; g < NUM_MAPS; g++) begin : g_clamp
    localparam int KIND = g % NUM_KINDS;
    assign pos[g] = clamp_pos(res[g], PIX_LO[KIND], PIX_HI[KIND]);
  end

  // Pack the result word, lowest field first.
  assign data_nxt = {2'b00,
                     pos[NUM_KINDS + KIND_BUB_Y][5:0],
                     pos[NUM_KINDS + KIND_BUB_X][5:0],
                     pos[NUM_KINDS + KIND_BAR_Y][5:0],
                     pos[NUM_KINDS + KIND_BAR_X],
                     pos[KIND_BUB_Y][5:0],
                     pos[KIND_BUB_X][5:0],
                     pos[KIND_BAR_Y][5:0],
                     pos[KIND_BAR_X],
                     mean_y,
                     mean_x};

  // Output register: a new result may enter as the held one leaves.
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* design/tilt_average_and_screen_map_core.sv */
// Channel  | Direction | Payload
// in_      | slave     | tdata: sample_x, sample_y
// out_     | master    | tdata: mean_x, mean_y, bar and bubble positions (new, then previous)
// cfg_     | write     | addr selects x_raw_low, x_raw_high, y_raw_low, y_raw_high
//
// Pairs are taken one per cycle until a block of BLOCK_SAMPLES is complete. The two mean
// lanes then form the averages by a reciprocal multiply; if a mean changed, the eight map
// lanes divide bit-serially and the result enters the output register.
// rst_n is synchronous: it clears sums, count and stored means and restores 370/590.
// The input stalls only while the averages and the maps are formed, or while a finished
// result waits for a held one.
`include "tilt_average_and_screen_map_core_macros.svh"

module tilt_average_and_screen_map_core
  import tasm_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 16,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // sample_x, sample_y
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // mean_x, mean_y, bar_x_pos, bar_y_pos, bubble_x_pos, bubble_y_pos, prev_bar_x_pos,
  // prev_bar_y_pos, prev_bubble_x_pos, prev_bubble_y_pos
  output logic [OUT_W-1:0]                        out_tdata,
  input  logic                                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
  input  logic [CFG_W-1:0]                        cfg_wdata
);

  localparam int CNT_W = $clog2(BLOCK_SAMPLES);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_MEAN = 4'b0010,
    ST_MAP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CFG_W-1:0]  x_raw_low_r;
  logic [CFG_W-1:0]  x_raw_high_r;
  logic [CFG_W-1:0]  y_raw_low_r;
  logic [CFG_W-1:0]  y_raw_high_r;
  logic [MEAN_W-1:0] last_mean_x_r;
  logic [MEAN_W-1:0] last_mean_y_r;
  logic [MEAN_W-1:0] mean_x;
  logic [MEAN_W-1:0] mean_y;
  logic              mean_done_x;
  logic              mean_done_y;
  logic              mean_done;
  logic              in_xfer;
  logic              block_last;
  logic              changed;
  logic              map_start;
  logic              map_done;
  logic              out_load;
  logic              can_load;
  logic [NUM_MAPS-1:0] map_done_v;
  map_res_t          map_res   [NUM_MAPS];
  logic [MEAN_W-1:0] lane_value [NUM_MAPS];
  logic [CFG_W-1:0]  lane_lo    [NUM_MAPS];
  logic [CFG_W-1:0]  lane_hi    [NUM_MAPS];

  // Input handshake and block position.
  assign in_tready  = (state_r == ST_ACC);
  assign in_xfer    = in_tvalid && in_tready;
  assign block_last = (count_r == CNT_W'(BLOCK_SAMPLES - 1));

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_raw_low_r  <= RAW_LOW_RST;
      x_raw_high_r <= RAW_HIGH_RST;
      y_raw_low_r  <= RAW_LOW_RST;
      y_raw_high_r <= RAW_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_X_RAW_LOW:  x_raw_low_r  <= cfg_wdata;
        CFG_X_RAW_HIGH: x_raw_high_r <= cfg_wdata;
        CFG_Y_RAW_LOW:  y_raw_low_r  <= cfg_wdata;
        CFG_Y_RAW_HIGH: y_raw_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Averaging lanes, one per axis.
  tasm_mean_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_mean_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .last   (block_last),
    .sample (in_tdata[SAMPLE_BITS-1:0]),
    .mean   (mean_x),
    .done   (mean_done_x)
  );

  tasm_mean_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_mean_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .last   (block_last),
    .sample (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .mean   (mean_y),
    .done   (mean_done_y)
  );

  assign mean_done = mean_done_x && mean_done_y;
  assign changed   = (mean_x != last_mean_x_r) || (mean_y != last_mean_y_r);
  assign map_start = (state_r == ST_MEAN) && mean_done && changed;

  // Map lanes: the first four take the new means, the last four the stored ones.
  for (genvar g = 0; g < NUM_MAPS; g++) begin : g_map
    localparam int KIND    = g % NUM_KINDS;
    localparam bit IS_X    = (KIND == KIND_BAR_X) || (KIND == KIND_BUB_X);
    localparam bit IS_PREV = (g >= NUM_KINDS);

    assign lane_value[g] = IS_PREV ? (IS_X ? last_mean_x_r : last_mean_y_r)
                                   : (IS_X ? mean_x : mean_y);
    assign lane_lo[g]    = IS_X ? x_raw_low_r : y_raw_low_r;
    assign lane_hi[g]    = IS_X ? x_raw_high_r : y_raw_high_r;

    tasm_map_lane #(
      .SPAN (PIX_HI[KIND] - PIX_LO[KIND])
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (map_start),
      .value  (lane_value[g]),
      .raw_lo (lane_lo[g]),
      .raw_hi (lane_hi[g]),
      .res    (map_res[g]),
      .done   (map_done_v[g])
    );
  end

  assign map_done = &map_done_v;
  assign out_load = (state_r == ST_OUT) && can_load;

  // Merging stage and output register.
  tasm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .mean_x     (mean_x),
    .mean_y     (mean_y),
    .res        (map_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .can_load   (can_load)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC: begin
        if (in_xfer && block_last) state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        if (mean_done) state_nxt = changed ? ST_MAP : ST_ACC;
      end
      ST_MAP: begin
        if (map_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (can_load) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_ACC;
      count_r       <= '0;
      last_mean_x_r <= '0;
      last_mean_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        count_r <= block_last ? '0 : count_r + 1'b1;
      end
      if (out_load) begin
        last_mean_x_r <= mean_x;
        last_mean_y_r <= mean_y;
      end
    end
  end

  // Checks on the sequencing.
  `TASM_ASSERT_NOW(a_emit_changed, out_load, changed, "result emitted for unchanged means")
  `TASM_ASSERT_NOW(a_count_idle, state_r != ST_ACC, count_r == '0, "count moved outside block")
  `TASM_ASSERT_NEXT(a_load_valid, out_load, out_tvalid, "loaded result not presented")
  `TASM_ASSERT_NOW(a_lanes_sync, map_done_v[0], map_done, "map lanes out of step")

endmodule
